// File: src/vasr_pkg.sv
// Shared constants and types for the voxel box sweep resolver.
`default_nettype none
package vasr_pkg;
  localparam int GRID_BITS_DEF = 5;
  localparam int FRAC_BITS_DEF = 12;
  localparam int HW_W = 14;
  localparam int BH_W = 15;
  localparam int MOVE_W = 16;
  localparam int VOX_W = 5;
  localparam int POS_W = 17;
  localparam int W = 24;  // signed working width for positions and bounds
  localparam logic [0:0] CFG_HALF_WIDTH = 1'b0;
  localparam logic [0:0] CFG_BOX_HEIGHT = 1'b1;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [1:0] {AX_X = 2'd0, AX_Y = 2'd1, AX_Z = 2'd2} axis_t;

  typedef struct packed {
    logic  clr_we;     // clearing pass write
    logic  load;       // capture a move transaction
    logic  wr_vox;     // write the input voxel
    logic  setup;      // compute the scan frame for axis
    logic  scan_init;  // place the scan cursor at the frame corner
    logic  scan_step;  // issue one map read and advance
    logic  eval;       // consider the voxel read last cycle
    logic  finish;     // clamp the axis
    axis_t axis;
  } ctl_t;

  typedef struct packed {
    logic skip;       // zero displacement or empty frame
    logic scan_last;  // cursor at final voxel
  } sts_t;
endpackage
`default_nettype wire

// File: src/vasr_ram.sv
// Generic single-port write, registered-read RAM.
`default_nettype none
module vasr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/vasr_datapath.sv
// Datapath: voxel map, position registers, scan frame and nearest-hit search.
`default_nettype none
module vasr_datapath #(
  parameter int GRID_BITS = vasr_pkg::GRID_BITS_DEF,
  parameter int FRAC_BITS = vasr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire vasr_pkg::ctl_t                ctl,
  output vasr_pkg::sts_t                     sts,
  input  wire logic [3*GRID_BITS-1:0]        clr_addr,
  input  wire logic [vasr_pkg::HW_W-1:0]     half_width,
  input  wire logic [vasr_pkg::BH_W-1:0]     box_height,
  input  wire logic [vasr_pkg::VOX_W-1:0]    in_voxel_x,
  input  wire logic [vasr_pkg::VOX_W-1:0]    in_voxel_y,
  input  wire logic [vasr_pkg::VOX_W-1:0]    in_voxel_z,
  input  wire logic                          in_voxel_solid,
  input  wire logic [vasr_pkg::POS_W-1:0]    in_start_x,
  input  wire logic [vasr_pkg::POS_W-1:0]    in_start_y,
  input  wire logic [vasr_pkg::POS_W-1:0]    in_start_z,
  input  wire logic signed [vasr_pkg::MOVE_W-1:0] in_move_x,
  input  wire logic signed [vasr_pkg::MOVE_W-1:0] in_move_y,
  input  wire logic signed [vasr_pkg::MOVE_W-1:0] in_move_z,
  output logic [vasr_pkg::POS_W-1:0]         out_end_x,
  output logic [vasr_pkg::POS_W-1:0]         out_end_y,
  output logic [vasr_pkg::POS_W-1:0]         out_end_z,
  output logic                               out_hit_x,
  output logic                               out_hit_y,
  output logic                               out_hit_z,
  output logic                               out_on_ground,
  output logic                               out_on_ceiling
);
  localparam int W = vasr_pkg::W;
  localparam int G = GRID_BITS;
  localparam int AW = 3 * G;
  localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
  localparam logic signed [W-1:0] POS_MAX = (W'(1) <<< (G + FRAC_BITS)) - W'(1);
  localparam logic signed [G+1:0] GMAX = (G+2)'((1 << G) - 1);

  logic signed [W-1:0] pos_r [3];
  logic signed [W-1:0] dlt_r [3];
  logic [2:0] hit_r;
  logic signed [G+1:0] lo_r [3];
  logic signed [G+1:0] hi_r [3];
  logic [G-1:0] cx_r, cy_r, cz_r;
  logic signed [W-1:0] prev_min_r, prev_max_r;
  logic [G-1:0] best_r;
  logic found_r;
  logic [G-1:0] rc_r;  // axis coordinate of the voxel in flight
  logic chk_r;

  logic signed [W-1:0] hw, bh, d, np;
  logic signed [W-1:0] bmin [3];
  logic signed [W-1:0] bmax [3];
  logic signed [G+1:0] flo [3];
  logic signed [G+1:0] fhi [3];
  logic [1:0] ax;
  logic [AW-1:0] waddr, raddr;
  logic we, wd, rbit;
  logic [G-1:0] cc;
  logic signed [W-1:0] cfar, cnear;
  logic ahead;

  assign ax = ctl.axis;
  assign hw = W'($signed({1'b0, half_width}));
  assign bh = W'($signed({1'b0, box_height}));
  assign d = dlt_r[ax];
  assign np = pos_r[ax] + d;

  // floor to voxel index, saturated to one step beyond the grid on either side
  function automatic logic signed [G+1:0] fl(input logic signed [W-1:0] v);
    logic signed [W-1:0] f;
    f = v >>> FRAC_BITS;
    if (f < 0) return -(G+2)'(1);
    if (f > W'(GMAX)) return (G+2)'(GMAX) + (G+2)'(1);
    return (G+2)'(f);
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [W-1:0] p;
      logic signed [W-1:0] pad;
      p = (a == int'(ax)) ? np : pos_r[a];
      pad = (a == int'(ax)) ? -W'(1) : W'(1);
      bmin[a] = (a == 1) ? p : p - hw;
      bmax[a] = (a == 1) ? p + bh : p + hw;
      flo[a] = fl(bmin[a] + pad);
      fhi[a] = fl(bmax[a] - pad);
      if (flo[a] < 0) flo[a] = '0;
      if (fhi[a] > GMAX) fhi[a] = GMAX;
    end
  end

  assign sts.skip = ctl.setup ? (d == 0 || flo[0] > fhi[0] || flo[1] > fhi[1] ||
                                 flo[2] > fhi[2]) : 1'b0;
  assign sts.scan_last = (cx_r == G'(hi_r[0])) && (cz_r == G'(hi_r[2])) &&
                         (cy_r == G'(hi_r[1]));

  assign we = ctl.clr_we | ctl.wr_vox;
  assign waddr = ctl.clr_we ? clr_addr : {in_voxel_y[G-1:0], in_voxel_z[G-1:0],
                                          in_voxel_x[G-1:0]};
  assign wd = ctl.clr_we ? 1'b0 : in_voxel_solid;
  assign raddr = {cy_r, cz_r, cx_r};

  vasr_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rbit)
  );

  assign cc = (ax == 2'(vasr_pkg::AX_X)) ? cx_r : (ax == 2'(vasr_pkg::AX_Y)) ? cy_r : cz_r;
  assign cnear = W'($signed({1'b0, rc_r})) <<< FRAC_BITS;
  assign cfar = cnear + ONE;
  assign ahead = (d > 0) ? !(cnear < prev_max_r - W'(1)) : !(cfar > prev_min_r + W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      chk_r <= ctl.scan_step;
      if (ctl.setup) found_r <= 1'b0;
      else if (chk_r && rbit && ahead)
        found_r <= 1'b1;
    end
    if (ctl.load) begin
      pos_r[0] <= W'($signed({1'b0, in_start_x}));
      pos_r[1] <= W'($signed({1'b0, in_start_y}));
      pos_r[2] <= W'($signed({1'b0, in_start_z}));
      dlt_r[0] <= W'(in_move_x);
      dlt_r[1] <= W'(in_move_y);
      dlt_r[2] <= W'(in_move_z);
      hit_r <= '0;
    end
    if (ctl.setup) begin
      prev_min_r <= (ax == 2'(vasr_pkg::AX_Y)) ? pos_r[ax] : pos_r[ax] - hw;
      prev_max_r <= (ax == 2'(vasr_pkg::AX_Y)) ? pos_r[ax] + bh : pos_r[ax] + hw;
      if (d != 0) pos_r[ax] <= np;
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= flo[a];
        hi_r[a] <= fhi[a];
      end
    end
    if (ctl.scan_init) begin
      cx_r <= G'(lo_r[0]);
      cy_r <= G'(lo_r[1]);
      cz_r <= G'(lo_r[2]);
    end else if (ctl.scan_step) begin
      rc_r <= cc;
      // advance x fastest, then z, then y
      if (cx_r != G'(hi_r[0])) cx_r <= cx_r + G'(1);
      else begin
        cx_r <= G'(lo_r[0]);
        if (cz_r != G'(hi_r[2])) cz_r <= cz_r + G'(1);
        else begin
          cz_r <= G'(lo_r[2]);
          cy_r <= cy_r + G'(1);
        end
      end
    end
    if (chk_r && rbit && ahead) begin
      if (!found_r || ((d > 0) ? (rc_r < best_r) : (rc_r > best_r))) best_r <= rc_r;
    end
    if (ctl.finish && found_r) begin
      hit_r[ax] <= 1'b1;
      if (d > 0)
        pos_r[ax] <= (W'($signed({1'b0, best_r})) <<< FRAC_BITS) -
                     ((ax == 2'(vasr_pkg::AX_Y)) ? bh : hw) - W'(1);
      else
        pos_r[ax] <= (W'($signed({1'b0, best_r})) <<< FRAC_BITS) + ONE +
                     ((ax == 2'(vasr_pkg::AX_Y)) ? W'(0) : hw) + W'(1);
    end
  end

  function automatic logic [vasr_pkg::POS_W-1:0] sat(input logic signed [W-1:0] v);
    if (v < 0) return '0;
    if (v > POS_MAX) return vasr_pkg::POS_W'(POS_MAX);
    return vasr_pkg::POS_W'(v);
  endfunction

  assign out_end_x = sat(pos_r[0]);
  assign out_end_y = sat(pos_r[1]);
  assign out_end_z = sat(pos_r[2]);
  assign out_hit_x = hit_r[0];
  assign out_hit_y = hit_r[1];
  assign out_hit_z = hit_r[2];
  assign out_on_ground = hit_r[1] && dlt_r[1] < 0;
  assign out_on_ceiling = hit_r[1] && dlt_r[1] > 0;
endmodule
`default_nettype wire

// File: src/vasr_ctrl.sv
// Controller: clearing pass, transaction handshake and axis sweep sequencing.
`default_nettype none
module vasr_ctrl #(
  parameter int GRID_BITS = vasr_pkg::GRID_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output vasr_pkg::ctl_t              ctl,
  input  wire vasr_pkg::sts_t         sts,
  output logic [3*GRID_BITS-1:0]      clr_addr
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SETUP, S_INIT, S_SCAN, S_DRAIN, S_FIN, S_OUT}
    state_t;
  state_t state_r, state_nxt;
  vasr_pkg::axis_t axis_r, axis_nxt;
  logic [3*GRID_BITS-1:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic acc;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign clr_addr = clr_r;
  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    axis_nxt = axis_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r;
    ctl = '0;
    ctl.axis = axis_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (in_command == vasr_pkg::CMD_WRITE) ctl.wr_vox = 1'b1;
          else begin
            ctl.load = 1'b1;
            axis_nxt = vasr_pkg::AX_Y;
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        ctl.setup = 1'b1;
        state_nxt = sts.skip ? S_FIN : S_INIT;
      end
      S_INIT: begin
        ctl.scan_init = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;  // last read lands
      S_FIN: begin
        ctl.finish = 1'b1;
        case (axis_r)
          vasr_pkg::AX_Y: begin axis_nxt = vasr_pkg::AX_X; state_nxt = S_SETUP; end
          vasr_pkg::AX_X: begin axis_nxt = vasr_pkg::AX_Z; state_nxt = S_SETUP; end
          default: begin out_valid_nxt = 1'b1; state_nxt = S_OUT; end
        endcase
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      axis_r <= vasr_pkg::AX_Y;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: src/voxel_aabb_sweep_resolver.sv
// Top level of the voxel box sweep resolver.
// After reset the block clears its 2^(3*GRID_BITS)-entry voxel map, one entry a
// cycle, before it takes a transaction. A voxel write goes into the map in its
// accept cycle. A move takes its accept cycle, then per axis with nonzero move a
// setup, a scan start, a scan of its frame one voxel at a time (set by the single
// read port of the map), a drain and a finish step; an axis with zero move or an
// empty frame takes setup and finish only; then the result is held until taken.
// One move is in flight at a time.
`default_nettype none
module voxel_aabb_sweep_resolver #(
  parameter int GRID_BITS = vasr_pkg::GRID_BITS_DEF,
  parameter int FRAC_BITS = vasr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [0:0]                     cfg_index,
  input  wire logic [vasr_pkg::BH_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_command,
  input  wire logic [vasr_pkg::VOX_W-1:0]     in_voxel_x,
  input  wire logic [vasr_pkg::VOX_W-1:0]     in_voxel_y,
  input  wire logic [vasr_pkg::VOX_W-1:0]     in_voxel_z,
  input  wire logic                           in_voxel_solid,
  input  wire logic [vasr_pkg::POS_W-1:0]     in_start_x,
  input  wire logic [vasr_pkg::POS_W-1:0]     in_start_y,
  input  wire logic [vasr_pkg::POS_W-1:0]     in_start_z,
  input  wire logic signed [vasr_pkg::MOVE_W-1:0] in_move_x,
  input  wire logic signed [vasr_pkg::MOVE_W-1:0] in_move_y,
  input  wire logic signed [vasr_pkg::MOVE_W-1:0] in_move_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [vasr_pkg::POS_W-1:0]          out_end_x,
  output logic [vasr_pkg::POS_W-1:0]          out_end_y,
  output logic [vasr_pkg::POS_W-1:0]          out_end_z,
  output logic                                out_hit_x,
  output logic                                out_hit_y,
  output logic                                out_hit_z,
  output logic                                out_on_ground,
  output logic                                out_on_ceiling
);
  logic [vasr_pkg::HW_W-1:0] half_width_r;
  logic [vasr_pkg::BH_W-1:0] box_height_r;
  vasr_pkg::ctl_t ctl;
  vasr_pkg::sts_t sts;
  logic [3*GRID_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= vasr_pkg::HW_W'(1229);
      box_height_r <= vasr_pkg::BH_W'(7373);
    end else if (cfg_we) begin
      case (cfg_index)
        vasr_pkg::CFG_HALF_WIDTH: half_width_r <= cfg_data[vasr_pkg::HW_W-1:0];
        vasr_pkg::CFG_BOX_HEIGHT: box_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vasr_ctrl #(.GRID_BITS(GRID_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .out_valid(out_valid), .out_ready(out_ready),
    .ctl(ctl), .sts(sts), .clr_addr(clr_addr)
  );

  vasr_datapath #(.GRID_BITS(GRID_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .clr_addr(clr_addr),
    .half_width(half_width_r), .box_height(box_height_r),
    .in_voxel_x(in_voxel_x), .in_voxel_y(in_voxel_y), .in_voxel_z(in_voxel_z),
    .in_voxel_solid(in_voxel_solid), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_start_z(in_start_z), .in_move_x(in_move_x), .in_move_y(in_move_y),
    .in_move_z(in_move_z), .out_end_x(out_end_x), .out_end_y(out_end_y),
    .out_end_z(out_end_z), .out_hit_x(out_hit_x), .out_hit_y(out_hit_y),
    .out_hit_z(out_hit_z), .out_on_ground(out_on_ground), .out_on_ceiling(out_on_ceiling)
  );
endmodule
`default_nettype wire

// File: src/vasr_checker.sv
// Port-level checker for the voxel box sweep resolver, bound to the top level.
`default_nettype none
module vasr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_hit_y,
  input wire logic out_on_ground,
  input wire logic out_on_ceiling
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result right after input");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_on_ground && out_on_ceiling)) else $error("ground and ceiling");
  a_ground_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_on_ground || out_on_ceiling) |-> out_hit_y)
    else $error("flag without y hit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind voxel_aabb_sweep_resolver vasr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit_y(out_hit_y),
  .out_on_ground(out_on_ground), .out_on_ceiling(out_on_ceiling)
);
`default_nettype wire

// File: tb/voxel_aabb_sweep_resolver_checker.sv
// Checker for the voxel box sweep resolver: predicts move results and compares them.
`default_nettype none
module voxel_aabb_sweep_resolver_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [vasr_pkg::BH_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic                        in_command,
  input  wire logic [4:0]                  in_voxel_x,
  input  wire logic [4:0]                  in_voxel_y,
  input  wire logic [4:0]                  in_voxel_z,
  input  wire logic                        in_voxel_solid,
  input  wire logic [16:0]                 in_start_x,
  input  wire logic [16:0]                 in_start_y,
  input  wire logic [16:0]                 in_start_z,
  input  wire logic [15:0]                 in_move_x,
  input  wire logic [15:0]                 in_move_y,
  input  wire logic [15:0]                 in_move_z,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [16:0]                 out_end_x,
  input  wire logic [16:0]                 out_end_y,
  input  wire logic [16:0]                 out_end_z,
  input  wire logic                        out_hit_x,
  input  wire logic                        out_hit_y,
  input  wire logic                        out_hit_z,
  input  wire logic                        out_on_ground,
  input  wire logic                        out_on_ceiling,
  output int                               fail_count,
  output int                               pending_moves,
  output int                               moves_seen,
  output int                               hits_seen
);
  import vasr_pkg::*;

  typedef struct packed {
    logic [16:0] ex, ey, ez;
    logic hx, hy, hz, gnd, ceil;
  } landing_t;

  localparam longint ONE_Q = 4096;
  localparam longint GRID = 32;

  bit solid_map [0:32767];
  longint hw_q, bh_q;
  landing_t landings [$];

  function automatic longint floor_div(longint v);
    if (v >= 0) return v >>> 12;
    return -(((-v) + ONE_Q - 1) >>> 12);
  endfunction

  // Move one axis in place; return 1 when a voxel stopped it.
  function automatic bit sweep_axis(ref longint p [3], input longint d, input int ax);
    longint prev, pmin, pmax, best, c, pad;
    longint bmin [3], bmax [3], lo [3], hi [3];
    bit found;
    found = 0;
    best = 0;
    if (d == 0) return 0;
    prev = p[ax];
    p[ax] = p[ax] + d;
    bmin[0] = p[0] - hw_q; bmax[0] = p[0] + hw_q;
    bmin[1] = p[1];        bmax[1] = p[1] + bh_q;
    bmin[2] = p[2] - hw_q; bmax[2] = p[2] + hw_q;
    for (int a = 0; a < 3; a++) begin
      pad = (a == ax) ? -1 : 1;
      lo[a] = floor_div(bmin[a] + pad);
      hi[a] = floor_div(bmax[a] - pad);
      if (lo[a] < 0) lo[a] = 0;
      if (hi[a] > GRID - 1) hi[a] = GRID - 1;
    end
    pmin = (ax == 1) ? prev : prev - hw_q;
    pmax = (ax == 1) ? prev + bh_q : prev + hw_q;
    for (longint y = lo[1]; y <= hi[1]; y++)
      for (longint z = lo[2]; z <= hi[2]; z++)
        for (longint x = lo[0]; x <= hi[0]; x++) begin
          if (!solid_map[y * 1024 + z * 32 + x]) continue;
          c = (ax == 0) ? x : (ax == 1) ? y : z;
          if (d > 0 && c * ONE_Q < pmax - 1) continue;
          if (d < 0 && (c + 1) * ONE_Q > pmin + 1) continue;
          if (!found) begin
            best = c;
            found = 1;
          end else if (d > 0 ? c < best : c > best) begin
            best = c;
          end
        end
    if (!found) return 0;
    if (d > 0) p[ax] = best * ONE_Q - ((ax == 1) ? bh_q : hw_q) - 1;
    else p[ax] = (best + 1) * ONE_Q + ((ax == 1) ? 0 : hw_q) + 1;
    return 1;
  endfunction

  function automatic logic [16:0] clamp_pos(longint v);
    if (v < 0) return '0;
    if (v > 131071) return 17'h1FFFF;
    return v[16:0];
  endfunction

  function automatic landing_t resolve_move();
    longint p [3];
    longint dy;
    landing_t r;
    p[0] = in_start_x;
    p[1] = in_start_y;
    p[2] = in_start_z;
    dy = longint'($signed(in_move_y));
    r.hy = sweep_axis(p, dy, 1);
    r.hx = sweep_axis(p, longint'($signed(in_move_x)), 0);
    r.hz = sweep_axis(p, longint'($signed(in_move_z)), 2);
    r.ex = clamp_pos(p[0]);
    r.ey = clamp_pos(p[1]);
    r.ez = clamp_pos(p[2]);
    r.gnd = r.hy && dy < 0;
    r.ceil = r.hy && dy > 0;
    return r;
  endfunction

  assign pending_moves = landings.size();

  always @(posedge clk) begin
    landing_t want, got;
    if (!rst_n) begin
      foreach (solid_map[i]) solid_map[i] = 0;
      hw_q = 1229;
      bh_q = 7373;
      landings.delete();
      fail_count = 0;
      moves_seen = 0;
      hits_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HALF_WIDTH) hw_q = cfg_data[HW_W-1:0];
        else hw_q = hw_q;
        if (cfg_index == CFG_BOX_HEIGHT) bh_q = cfg_data;
      end
      if (out_valid && out_ready) begin
        got = '{out_end_x, out_end_y, out_end_z, out_hit_x, out_hit_y, out_hit_z,
                out_on_ground, out_on_ceiling};
        moves_seen++;
        if (got.hx || got.hy || got.hz) hits_seen++;
        if (landings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = landings.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_WRITE)
          solid_map[in_voxel_y * 1024 + in_voxel_z * 32 + in_voxel_x] = in_voxel_solid;
        else
          landings.push_back(resolve_move());
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/voxel_aabb_sweep_resolver_tb.sv
// Testbench top for the voxel box sweep resolver: stimulus, configuration and verdict.
`default_nettype none
module voxel_aabb_sweep_resolver_tb;
  import vasr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [0:0] cfg_index = CFG_HALF_WIDTH;
  logic [BH_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic in_command = CMD_WRITE;
  logic [4:0] in_voxel_x = 0, in_voxel_y = 0, in_voxel_z = 0;
  logic in_voxel_solid = 0;
  logic [16:0] in_start_x = 0, in_start_y = 0, in_start_z = 0;
  logic signed [15:0] in_move_x = 0, in_move_y = 0, in_move_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [16:0] out_end_x, out_end_y, out_end_z;
  logic out_hit_x, out_hit_y, out_hit_z, out_on_ground, out_on_ceiling;
  int fail_count, pending_moves, moves_seen, hits_seen;
  int idle_cycles = 0;
  bit calm = 0;
  bit hold_off = 0;
  int items_sent = 0;

  always #6 clk = ~clk;

  voxel_aabb_sweep_resolver dut (.*);

  voxel_aabb_sweep_resolver_checker chk (.*);

  // Watchdog: cycles with no transaction on either channel; covers the map clear.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  // Hold valid across back-to-back transactions; drop it only for an idle burst or a drain.
  task automatic send(input logic cmd, input logic [4:0] vx, vy, vz, input logic sol,
                      input logic [16:0] sx, sy, sz, input logic [15:0] mx, my, mz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_voxel_x <= vx; in_voxel_y <= vy; in_voxel_z <= vz;
    in_voxel_solid <= sol;
    in_start_x <= sx; in_start_y <= sy; in_start_z <= sz;
    in_move_x <= mx; in_move_y <= my; in_move_z <= mz;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic put_voxel(input logic [4:0] x, y, z, input logic s);
    send(CMD_WRITE, x, y, z, s, 17'($urandom), 17'($urandom), 17'($urandom),
         16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic move_box(input logic [16:0] sx, sy, sz, input logic [15:0] mx, my, mz);
    send(CMD_MOVE, 5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom),
         sx, sy, sz, mx, my, mz);
  endtask

  function automatic logic [15:0] pick_move();
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [16:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return 17'($urandom);
    return 17'($urandom_range(4, 27) * 4096 + $urandom_range(0, 4095));
  endfunction

  // Wait for the block to drain, then let the tail of a write settle.
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending_moves != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [BH_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int bx, by, bz;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: floor slab, walls, extremes, region edges.
    for (int i = 0; i < 4; i++) put_voxel(5'd10 + 5'(i), 5'd4, 5'd10, 1'b1);
    put_voxel(5'd10, 5'd4, 5'd11, 1'b1);
    put_voxel(5'd31, 5'd31, 5'd31, 1'b1);
    put_voxel(5'd0, 5'd0, 5'd0, 1'b1);
    put_voxel(5'd12, 5'd7, 5'd10, 1'b1);
    put_voxel(5'd13, 5'd5, 5'd10, 1'b1);
    put_voxel(5'd13, 5'd5, 5'd10, 1'b0);
    move_box(17'd10*4096+2048, 17'd5*4096+100, 17'd10*4096+2048, 0, -16'sd16384, 0);
    move_box(17'd11*4096+2048, 17'd5*4096, 17'd10*4096+2048, 0, 16'sd16384, 0);
    move_box(17'd9*4096, 17'd5*4096, 17'd10*4096+2048, 16'sd16384, 0, 0);
    move_box(17'd14*4096, 17'd5*4096, 17'd10*4096+2048, -16'sd16384, 0, 0);
    move_box(17'd10*4096+2048, 17'd5*4096, 17'd12*4096, 0, 0, -16'sd16384);
    move_box(0, 0, 0, -16'sd16384, -16'sd16384, -16'sd16384);
    move_box(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'sd16384, 16'sd16384, 16'sd16384);
    move_box(17'd5000, 17'd5000, 17'd5000, 0, 0, 0);
    move_box(17'd1000, 17'd1000, 17'd1000, 16'h8000, 16'h7FFF, 16'hFFFF);
    move_box(17'd130000, 17'd2000, 17'd4096, 16'sd3000, -16'sd100, 16'sd1);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_HALF_WIDTH, 0); write_reg(CFG_BOX_HEIGHT, 0); end
        1: begin write_reg(CFG_HALF_WIDTH, 8192); write_reg(CFG_BOX_HEIGHT, 16384); end
        2: begin write_reg(CFG_HALF_WIDTH, 14'h3FFF); write_reg(CFG_BOX_HEIGHT, 15'h7FFF); end
        3: begin write_reg(CFG_HALF_WIDTH, 1229); write_reg(CFG_BOX_HEIGHT, 7373); end
        default: begin
          write_reg(CFG_HALF_WIDTH, BH_W'($urandom_range(0, 8192)));
          write_reg(CFG_BOX_HEIGHT, BH_W'($urandom_range(0, 16384)));
        end
      endcase
      if (ph == 5) calm = 1;
      for (int k = 0; k < 220; k++) begin
        if (ph == 2 && k == 30) hold_off = 1;
        if ($urandom_range(0, 2) == 0) begin
          // Build terrain, mostly solid voxels, clustered near the middle of the region.
          bx = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(6, 25);
          by = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(2, 20);
          bz = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(6, 25);
          put_voxel(5'(bx), 5'(by), 5'(bz), $urandom_range(0, 3) != 0);
        end else begin
          move_box(pick_pos(), pick_pos(), pick_pos(), pick_move(), pick_move(), pick_move());
        end
      end
      drain();
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d items, %0d move results checked, %0d with a blocked axis.",
             items_sent, moves_seen, hits_seen);
    if (fail_count == 0 && pending_moves == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
src/vasr_pkg.sv
src/vasr_ram.sv
src/vasr_datapath.sv
src/vasr_ctrl.sv
src/voxel_aabb_sweep_resolver.sv
src/vasr_checker.sv
tb/voxel_aabb_sweep_resolver_checker.sv
tb/voxel_aabb_sweep_resolver_tb.sv
